@@ hdl/spg_pkg.sv @@
// Shared constants, register codes and the CORDIC angle table of the spiral point generator.
`timescale 1ns / 1ps
package spg_pkg;

  localparam int ADDR_W = 5;

  // Register indexes (byte address / 4).
  localparam logic [2:0] REG_POINT_COUNT = 3'd0;
  localparam logic [2:0] REG_MIN_RADIUS  = 3'd1;
  localparam logic [2:0] REG_MAX_RADIUS  = 3'd2;
  localparam logic [2:0] REG_TURNS       = 3'd3;
  localparam logic [2:0] REG_START_ANGLE = 3'd4;
  localparam logic [2:0] REG_HEIGHT_STEP = 3'd5;
  localparam logic [2:0] REG_SPIRAL_KIND = 3'd6;
  localparam logic [2:0] REG_KEEP_DIR    = 3'd7;

  // Spiral laws. The unused code yields a zero radius.
  localparam logic [1:0] KIND_LINEAR = 2'd0;
  localparam logic [1:0] KIND_LOG    = 2'd1;
  localparam logic [1:0] KIND_SQRT   = 2'd2;
  localparam logic [1:0] KIND_NONE   = 2'd3;

  // CORDIC gain compensation, Q1.30.
  localparam logic [29:0] KINV_Q30 = 30'd652032874;

  // atan(2^-s) with one turn equal to 2^32.
  function automatic logic [31:0] arc_angle(input logic [4:0] s);
    logic [31:0] v;
    case (s)
      5'd0:    v = 32'd536870912;
      5'd1:    v = 32'd316933406;
      5'd2:    v = 32'd167458907;
      5'd3:    v = 32'd85004756;
      5'd4:    v = 32'd42667331;
      5'd5:    v = 32'd21354465;
      5'd6:    v = 32'd10679838;
      5'd7:    v = 32'd5340245;
      5'd8:    v = 32'd2670163;
      5'd9:    v = 32'd1335087;
      5'd10:   v = 32'd667544;
      5'd11:   v = 32'd333772;
      5'd12:   v = 32'd166886;
      5'd13:   v = 32'd83443;
      5'd14:   v = 32'd41722;
      5'd15:   v = 32'd20861;
      5'd16:   v = 32'd10431;
      5'd17:   v = 32'd5215;
      5'd18:   v = 32'd2608;
      5'd19:   v = 32'd1304;
      5'd20:   v = 32'd652;
      5'd21:   v = 32'd326;
      5'd22:   v = 32'd163;
      5'd23:   v = 32'd81;
      5'd24:   v = 32'd41;
      5'd25:   v = 32'd20;
      5'd26:   v = 32'd10;
      5'd27:   v = 32'd5;
      5'd28:   v = 32'd3;
      5'd29:   v = 32'd1;
      5'd30:   v = 32'd1;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

endpackage

@@ hdl/spiral_point_generator_top.sv @@
// Spiral point generator: a sequencer around one shared multiplier and a shift-subtract unit.
`timescale 1ns / 1ps
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+----------------------------------------
//  in      | input     | in_valid / in_ready    | in_center_x, in_center_y, in_center_z
//  out     | output    | out_valid / out_ready  | out_point_x/y/z, out_last_point
//  cfg     | input     | APB psel/penable/pready| paddr, pwdata, prdata
//
//  One center yields N points. Each point passes the divider, the angle and height states,
//  the rotation init, CORDIC_STEPS rotation steps and the output state, plus the radius:
//  two multiplies for linear, a square root and the two multiplies, or two 16-step log2 loops
//  and sixteen square roots on the shared unit (log). in_ready is high only between centers.
//  A finished point waits in the output register while the next one is worked on; the
//  sequencer stalls only when a second point is ready before the first is taken.
//  Reset is synchronous and restores the register defaults; no clearing pass is needed.
module spiral_point_generator_top #(
  parameter int MAX_POINTS   = 64,
  parameter int CORDIC_STEPS = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic signed [31:0]         in_center_x,
  input  logic signed [31:0]         in_center_y,
  input  logic signed [31:0]         in_center_z,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [31:0]         out_point_x,
  output logic signed [31:0]         out_point_y,
  output logic signed [31:0]         out_point_z,
  output logic                       out_last_point,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [spg_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);

  localparam int CAP = (MAX_POINTS < 127) ? MAX_POINTS : 127;
  localparam logic [6:0] CAP_N = 7'(CAP);
  localparam logic [5:0] ROT_LAST = 6'(CORDIC_STEPS - 1);

  typedef enum logic [4:0] {
    S_IDLE, S_DIV, S_PT, S_Z, S_SQ, S_LIN1, S_LIN2, S_LG_LD, S_LG_IT, S_LG_D,
    S_LG_M, S_LG_E, S_EX_SQ, S_EX_MUL, S_LG_R, S_LG_S, S_ROT_INIT, S_ROT, S_OUT
  } state_t;

  // Configuration registers.
  logic [6:0]  cfg_count_r;
  logic [23:0] cfg_min_r, cfg_max_r, cfg_height_r;
  logic [15:0] cfg_turns_r, cfg_start_r;
  logic [1:0]  cfg_kind_r;
  logic        cfg_keep_r;

  // Control.
  state_t      state_r, state_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic [6:0]  idx_r, idx_nxt, n_r, n_nxt, den_r, den_nxt;
  logic [3:0]  ex_j_r, ex_j_nxt;
  logic        lg_sel_r, lg_sel_nxt;
  logic        out_valid_r, out_valid_nxt;

  // Datapath.
  logic signed [31:0] cx_r, cx_nxt, cy_r, cy_nxt, cz_r, cz_nxt;
  logic [22:0] dv_q_r, dv_q_nxt;
  logic [6:0]  dv_rem_r, dv_rem_nxt;
  logic [16:0] p_r, p_nxt, w_r, w_nxt;
  logic [31:0] pt_r, pt_nxt, ang_r, ang_nxt, zm_r, zm_nxt;
  logic [63:0] acc_r, acc_nxt;
  logic [23:0] r_r, r_nxt;
  logic [63:0] sq_v_r, sq_v_nxt, sq_res_r, sq_res_nxt, sq_bit_r, sq_bit_nxt;
  logic [30:0] lg_x_r, lg_x_nxt;
  logic [15:0] lg_frac_r, lg_frac_nxt;
  logic [4:0]  lg_e_r, lg_e_nxt;
  logic [20:0] lmax_r, lmax_nxt, lmin_r, lmin_nxt, mag_r, mag_nxt, dm_r, dm_nxt;
  logic        dneg_r, dneg_nxt;
  logic [5:0]  ek_r, ek_nxt;
  logic [15:0] ef_r, ef_nxt;
  logic [31:0] c_r, c_nxt, mant_r, mant_nxt;
  logic signed [43:0] x_r, x_nxt, y_r, y_nxt;
  logic signed [33:0] a_r, a_nxt;
  logic signed [31:0] ox_r, oy_r, oz_r;
  logic        olast_r;

  // Shared multiplier.
  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;

  // Helpers.
  logic        cfg_wr, in_acc, out_load, is_last;
  logic [6:0]  n_acc;
  logic        hs_neg;
  logic [23:0] hmag;
  logic [63:0] sq_rb;
  logic        sq_ge;
  logic [63:0] sq_v_step, sq_res_step;
  logic [7:0]  dv_sh;
  logic        dv_ge;
  logic [23:0] lg_v;
  logic [4:0]  lg_msb;
  logic [30:0] lg_norm;
  logic [31:0] lg_t;
  logic signed [21:0] lg_diff;
  logic [37:0] lg_dm_sum;
  logic [22:0] lg_off;
  logic [5:0]  lg_s;
  logic [63:0] lg_sum, lg_rr;
  logic [39:0] lin_sum;
  logic [55:0] z_sum;
  logic [31:0] ang_sum;
  logic [39:0] rot_x0;
  logic signed [33:0] ang_s, arc34;
  logic        fold_hi, fold_lo;
  logic [4:0]  cs;
  logic signed [43:0] xs, ys, dx, dy;
  logic signed [33:0] dz;
  logic signed [44:0] px_sum, py_sum, pz_sum;

  function automatic logic signed [31:0] sat32(input logic signed [44:0] v);
    logic signed [31:0] o;
    if (v > 45'sd2147483647) o = 32'sh7fffffff;
    else if (v < -45'sd2147483648) o = 32'sh80000000;
    else o = v[31:0];
    return o;
  endfunction

  assign pready    = 1'b1;
  assign cfg_wr    = psel & penable & pwrite;
  assign in_ready  = (state_r == S_IDLE);
  assign in_acc    = in_valid & in_ready;
  assign out_valid = out_valid_r;
  assign out_point_x = ox_r;
  assign out_point_y = oy_r;
  assign out_point_z = oz_r;
  assign out_last_point = olast_r;

  always_comb begin
    case (paddr[4:2])
      spg_pkg::REG_POINT_COUNT: prdata = {25'd0, cfg_count_r};
      spg_pkg::REG_MIN_RADIUS:  prdata = {8'd0, cfg_min_r};
      spg_pkg::REG_MAX_RADIUS:  prdata = {8'd0, cfg_max_r};
      spg_pkg::REG_TURNS:       prdata = {16'd0, cfg_turns_r};
      spg_pkg::REG_START_ANGLE: prdata = {16'd0, cfg_start_r};
      spg_pkg::REG_HEIGHT_STEP: prdata = {8'd0, cfg_height_r};
      spg_pkg::REG_SPIRAL_KIND: prdata = {30'd0, cfg_kind_r};
      spg_pkg::REG_KEEP_DIR:    prdata = {31'd0, cfg_keep_r};
      default:                  prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_count_r  <= 7'd16;
      cfg_min_r    <= 24'd0;
      cfg_max_r    <= 24'd256000;
      cfg_turns_r  <= 16'd768;
      cfg_start_r  <= 16'd0;
      cfg_height_r <= 24'd0;
      cfg_kind_r   <= spg_pkg::KIND_LINEAR;
      cfg_keep_r   <= 1'b1;
    end else if (cfg_wr) begin
      case (paddr[4:2])
        spg_pkg::REG_POINT_COUNT: cfg_count_r  <= pwdata[6:0];
        spg_pkg::REG_MIN_RADIUS:  cfg_min_r    <= pwdata[23:0];
        spg_pkg::REG_MAX_RADIUS:  cfg_max_r    <= pwdata[23:0];
        spg_pkg::REG_TURNS:       cfg_turns_r  <= pwdata[15:0];
        spg_pkg::REG_START_ANGLE: cfg_start_r  <= pwdata[15:0];
        spg_pkg::REG_HEIGHT_STEP: cfg_height_r <= pwdata[23:0];
        spg_pkg::REG_SPIRAL_KIND: cfg_kind_r   <= pwdata[1:0];
        spg_pkg::REG_KEEP_DIR:    cfg_keep_r   <= pwdata[0];
        default: ;
      endcase
    end
  end

  assign n_acc  = (cfg_count_r > CAP_N) ? CAP_N : cfg_count_r;
  assign hs_neg = cfg_height_r[23];
  assign hmag   = hs_neg ? (24'd0 - cfg_height_r) : cfg_height_r;
  assign is_last = (idx_r == n_r - 7'd1);
  assign out_load = (state_r == S_OUT) && (!out_valid_r || out_ready);

  // Multiplier operand selection.
  always_comb begin
    mul_a = 32'd0;
    mul_b = 32'd0;
    case (state_r)
      S_PT:       begin mul_a = {15'd0, p_r};   mul_b = {16'd0, cfg_turns_r}; end
      S_Z:        begin mul_a = {8'd0, hmag};   mul_b = pt_r; end
      S_LIN1:     begin mul_a = {8'd0, cfg_min_r}; mul_b = {15'd0, 17'h10000 - w_r}; end
      S_LIN2:     begin mul_a = {8'd0, cfg_max_r}; mul_b = {15'd0, w_r}; end
      S_LG_IT:    begin mul_a = {1'b0, lg_x_r}; mul_b = {1'b0, lg_x_r}; end
      S_LG_M:     begin mul_a = {11'd0, mag_r}; mul_b = {15'd0, p_r}; end
      S_EX_MUL:   begin mul_a = mant_r;         mul_b = c_r; end
      S_LG_R:     begin mul_a = {8'd0, cfg_min_r}; mul_b = mant_r; end
      S_ROT_INIT: begin mul_a = {8'd0, r_r};    mul_b = {2'd0, spg_pkg::KINV_Q30}; end
      default: ;
    endcase
  end
  assign mul_p = mul_a * mul_b;

  // Square root step, one result bit per cycle.
  assign sq_rb       = sq_res_r + sq_bit_r;
  assign sq_ge       = (sq_v_r >= sq_rb);
  assign sq_v_step   = sq_ge ? (sq_v_r - sq_rb) : sq_v_r;
  assign sq_res_step = sq_ge ? ((sq_res_r >> 1) + sq_bit_r) : (sq_res_r >> 1);

  // Restoring division step.
  assign dv_sh = {dv_rem_r, dv_q_r[22]};
  assign dv_ge = (dv_sh >= {1'b0, den_r});

  // log2 normalization.
  assign lg_v = lg_sel_r ? cfg_min_r : cfg_max_r;
  always_comb begin
    lg_msb = 5'd0;
    for (int k = 0; k < 24; k++) begin
      if (lg_v[k]) lg_msb = 5'(k);
    end
  end
  assign lg_norm   = {7'd0, lg_v} << (5'd30 - lg_msb);
  assign lg_t      = mul_p[61:30];
  assign lg_diff   = $signed({1'b0, lmax_r}) - $signed({1'b0, lmin_r});
  assign lg_dm_sum = mul_p[37:0] + 38'd32768;
  assign lg_off    = (dneg_r ? (23'd0 - {2'd0, dm_r}) : {2'd0, dm_r}) + 23'h200000;
  assign lg_s      = 6'd62 - ek_r;
  assign lg_sum    = acc_r + (64'd1 << (lg_s - 6'd1));
  assign lg_rr     = lg_sum >> lg_s;

  assign lin_sum = acc_r[39:0] + mul_p[39:0] + 40'd32768;
  assign z_sum   = mul_p[55:0] + 56'h800000;
  assign ang_sum = {cfg_start_r, 16'd0} + {pt_r[23:0], 8'd0};

  // CORDIC.
  assign rot_x0  = mul_p[53:14];
  assign ang_s   = 34'(signed'(ang_r));
  assign fold_hi = (ang_s > 34'sd1073741824);
  assign fold_lo = (ang_s < -34'sd1073741824);
  assign cs      = cnt_r[4:0];
  assign xs      = x_r >>> cs;
  assign ys      = y_r >>> cs;
  assign arc34   = signed'({2'b00, spg_pkg::arc_angle(cs)});

  assign dx = (x_r + 44'sd32768) >>> 16;
  assign dy = (y_r + 44'sd32768) >>> 16;
  assign dz = hs_neg ? -$signed({2'b00, zm_r}) : $signed({2'b00, zm_r});
  assign px_sum = 45'(cx_r) + 45'(dx);
  assign py_sum = 45'(cy_r) + 45'(dy);
  assign pz_sum = 45'(cz_r) + 45'(dz);

  always_comb begin
    state_nxt = state_r;     cnt_nxt = cnt_r;       idx_nxt = idx_r;
    n_nxt = n_r;             den_nxt = den_r;       ex_j_nxt = ex_j_r;
    lg_sel_nxt = lg_sel_r;   out_valid_nxt = out_valid_r & ~out_ready;
    cx_nxt = cx_r;  cy_nxt = cy_r;  cz_nxt = cz_r;
    dv_q_nxt = dv_q_r;       dv_rem_nxt = dv_rem_r;
    p_nxt = p_r;  w_nxt = w_r;  pt_nxt = pt_r;  ang_nxt = ang_r;  zm_nxt = zm_r;
    acc_nxt = acc_r;  r_nxt = r_r;
    sq_v_nxt = sq_v_r;  sq_res_nxt = sq_res_r;  sq_bit_nxt = sq_bit_r;
    lg_x_nxt = lg_x_r;  lg_frac_nxt = lg_frac_r;  lg_e_nxt = lg_e_r;
    lmax_nxt = lmax_r;  lmin_nxt = lmin_r;  mag_nxt = mag_r;  dm_nxt = dm_r;
    dneg_nxt = dneg_r;  ek_nxt = ek_r;  ef_nxt = ef_r;  c_nxt = c_r;  mant_nxt = mant_r;
    x_nxt = x_r;  y_nxt = y_r;  a_nxt = a_r;

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          cx_nxt = in_center_x;
          cy_nxt = in_center_y;
          cz_nxt = in_center_z;
          n_nxt = n_acc;
          den_nxt = (n_acc > 7'd1) ? (n_acc - 7'd1) : 7'd1;
          idx_nxt = 7'd0;
          dv_q_nxt = 23'd0;
          dv_rem_nxt = 7'd0;
          cnt_nxt = 6'd0;
          if (n_acc != 7'd0) state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        dv_q_nxt = {dv_q_r[21:0], dv_ge};
        dv_rem_nxt = dv_ge ? 7'(dv_sh - {1'b0, den_r}) : dv_sh[6:0];
        cnt_nxt = cnt_r + 6'd1;
        if (cnt_r == 6'd22) begin
          p_nxt = dv_q_nxt[16:0];
          state_nxt = S_PT;
        end
      end
      S_PT: begin
        pt_nxt = mul_p[31:0];
        state_nxt = S_Z;
      end
      S_Z: begin
        zm_nxt = z_sum[55:24];
        ang_nxt = cfg_keep_r ? ang_sum : (32'd0 - ang_sum);
        w_nxt = p_r;
        case (cfg_kind_r)
          spg_pkg::KIND_LINEAR: state_nxt = S_LIN1;
          spg_pkg::KIND_SQRT: begin
            sq_v_nxt = {15'd0, p_r, 32'd0} >> 16;
            sq_res_nxt = 64'd0;
            sq_bit_nxt = 64'h4000_0000_0000_0000;
            cnt_nxt = 6'd0;
            state_nxt = S_SQ;
          end
          spg_pkg::KIND_LOG: begin
            if (cfg_min_r == 24'd0) begin
              state_nxt = S_LIN1;
            end else if (cfg_max_r == 24'd0) begin
              r_nxt = (p_r == 17'd0) ? cfg_min_r : 24'd0;
              state_nxt = S_ROT_INIT;
            end else begin
              lg_sel_nxt = 1'b0;
              state_nxt = S_LG_LD;
            end
          end
          default: begin
            r_nxt = 24'd0;
            state_nxt = S_ROT_INIT;
          end
        endcase
      end
      S_SQ: begin
        sq_v_nxt = sq_v_step;
        sq_res_nxt = sq_res_step;
        sq_bit_nxt = sq_bit_r >> 2;
        cnt_nxt = cnt_r + 6'd1;
        if (cnt_r == 6'd31) begin
          w_nxt = sq_res_step[16:0];
          state_nxt = S_LIN1;
        end
      end
      S_LIN1: begin
        acc_nxt = mul_p;
        state_nxt = S_LIN2;
      end
      S_LIN2: begin
        r_nxt = lin_sum[39:16];
        state_nxt = S_ROT_INIT;
      end
      S_LG_LD: begin
        lg_x_nxt = lg_norm;
        lg_e_nxt = lg_msb;
        lg_frac_nxt = 16'd0;
        cnt_nxt = 6'd0;
        state_nxt = S_LG_IT;
      end
      S_LG_IT: begin
        // Squaring doubles the log; an overflow past 2.0 yields the next fraction bit.
        lg_x_nxt = lg_t[31] ? lg_t[31:1] : lg_t[30:0];
        lg_frac_nxt = {lg_frac_r[14:0], lg_t[31]};
        cnt_nxt = cnt_r + 6'd1;
        if (cnt_r == 6'd15) begin
          if (!lg_sel_r) begin
            lmax_nxt = {lg_e_r, lg_frac_nxt};
            lg_sel_nxt = 1'b1;
            state_nxt = S_LG_LD;
          end else begin
            lmin_nxt = {lg_e_r, lg_frac_nxt};
            state_nxt = S_LG_D;
          end
        end
      end
      S_LG_D: begin
        dneg_nxt = lg_diff[21];
        mag_nxt = lg_diff[21] ? 21'(-lg_diff) : lg_diff[20:0];
        state_nxt = S_LG_M;
      end
      S_LG_M: begin
        dm_nxt = lg_dm_sum[36:16];
        state_nxt = S_LG_E;
      end
      S_LG_E: begin
        ek_nxt = lg_off[21:16];
        ef_nxt = lg_off[15:0];
        c_nxt = 32'h8000_0000;
        mant_nxt = 32'h4000_0000;
        ex_j_nxt = 4'd0;
        sq_v_nxt = 64'h2000_0000_0000_0000;
        sq_res_nxt = 64'd0;
        sq_bit_nxt = 64'h4000_0000_0000_0000;
        cnt_nxt = 6'd0;
        state_nxt = S_EX_SQ;
      end
      S_EX_SQ: begin
        sq_v_nxt = sq_v_step;
        sq_res_nxt = sq_res_step;
        sq_bit_nxt = sq_bit_r >> 2;
        cnt_nxt = cnt_r + 6'd1;
        if (cnt_r == 6'd31) begin
          c_nxt = sq_res_step[31:0];
          state_nxt = S_EX_MUL;
        end
      end
      S_EX_MUL: begin
        // Step j holds 2^(2^-(j+1)); the fraction is consumed from its top bit down.
        if (ef_r[~ex_j_r]) mant_nxt = mul_p[61:30];
        if (ex_j_r == 4'd15) begin
          state_nxt = S_LG_R;
        end else begin
          ex_j_nxt = ex_j_r + 4'd1;
          sq_v_nxt = {2'd0, c_r, 30'd0};
          sq_res_nxt = 64'd0;
          sq_bit_nxt = 64'h4000_0000_0000_0000;
          cnt_nxt = 6'd0;
          state_nxt = S_EX_SQ;
        end
      end
      S_LG_R: begin
        acc_nxt = mul_p;
        state_nxt = S_LG_S;
      end
      S_LG_S: begin
        r_nxt = (lg_rr[63:24] != 40'd0) ? 24'hFFFFFF : lg_rr[23:0];
        state_nxt = S_ROT_INIT;
      end
      S_ROT_INIT: begin
        // Angles beyond a quarter turn are folded by a half turn and a sign flip.
        y_nxt = 44'sd0;
        if (fold_hi) begin
          a_nxt = ang_s - 34'sd2147483648;
          x_nxt = -$signed({4'd0, rot_x0});
        end else if (fold_lo) begin
          a_nxt = ang_s + 34'sd2147483648;
          x_nxt = -$signed({4'd0, rot_x0});
        end else begin
          a_nxt = ang_s;
          x_nxt = $signed({4'd0, rot_x0});
        end
        cnt_nxt = 6'd0;
        state_nxt = S_ROT;
      end
      S_ROT: begin
        if (!a_r[33]) begin
          x_nxt = x_r - ys;
          y_nxt = y_r + xs;
          a_nxt = a_r - arc34;
        end else begin
          x_nxt = x_r + ys;
          y_nxt = y_r - xs;
          a_nxt = a_r + arc34;
        end
        cnt_nxt = cnt_r + 6'd1;
        if (cnt_r == ROT_LAST) state_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_load) begin
          out_valid_nxt = 1'b1;
          if (is_last) begin
            idx_nxt = 7'd0;
            state_nxt = S_IDLE;
          end else begin
            idx_nxt = idx_r + 7'd1;
            dv_q_nxt = {idx_r + 7'd1, 16'd0};
            dv_rem_nxt = 7'd0;
            cnt_nxt = 6'd0;
            state_nxt = S_DIV;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= 6'd0;
      idx_r       <= 7'd0;
      n_r         <= 7'd0;
      den_r       <= 7'd1;
      ex_j_r      <= 4'd0;
      lg_sel_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      idx_r       <= idx_nxt;
      n_r         <= n_nxt;
      den_r       <= den_nxt;
      ex_j_r      <= ex_j_nxt;
      lg_sel_r    <= lg_sel_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cx_r <= cx_nxt;  cy_r <= cy_nxt;  cz_r <= cz_nxt;
    dv_q_r <= dv_q_nxt;  dv_rem_r <= dv_rem_nxt;
    p_r <= p_nxt;  w_r <= w_nxt;  pt_r <= pt_nxt;  ang_r <= ang_nxt;  zm_r <= zm_nxt;
    acc_r <= acc_nxt;  r_r <= r_nxt;
    sq_v_r <= sq_v_nxt;  sq_res_r <= sq_res_nxt;  sq_bit_r <= sq_bit_nxt;
    lg_x_r <= lg_x_nxt;  lg_frac_r <= lg_frac_nxt;  lg_e_r <= lg_e_nxt;
    lmax_r <= lmax_nxt;  lmin_r <= lmin_nxt;  mag_r <= mag_nxt;  dm_r <= dm_nxt;
    dneg_r <= dneg_nxt;  ek_r <= ek_nxt;  ef_r <= ef_nxt;  c_r <= c_nxt;
    mant_r <= mant_nxt;
    x_r <= x_nxt;  y_r <= y_nxt;  a_r <= a_nxt;
    if (out_load) begin
      ox_r    <= sat32(px_sum);
      oy_r    <= sat32(py_sum);
      oz_r    <= sat32(pz_sum);
      olast_r <= is_last;
    end
  end

  a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> (idx_r < n_r))
    else $error("point index ran past the point count");

  a_log_normalized: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_LG_IT) |-> lg_x_r[30])
    else $error("log2 mantissa lost its normalization");

  a_log_shift_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_LG_S) |-> ((ek_r >= 6'd8) && (ek_r <= 6'd55)))
    else $error("exponent out of range for the radius shift");

  a_cordic_angle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ROT) |-> ((a_r <= 34'sd2147483648) && (a_r >= -34'sd2147483648)))
    else $error("CORDIC residual angle out of range");

endmodule
